FILE: rtl/multi_channel_encoder_speed_macros.svh
// Assertion macros for the encoder speed block.
// Used by rtl/multi_channel_encoder_speed.sv; expects clk and arst_n in scope.
`ifndef MULTI_CHANNEL_ENCODER_SPEED_MACROS_SVH
`define MULTI_CHANNEL_ENCODER_SPEED_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MCES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mces assertion failed");
// next-cycle implication
`define MCES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mces assertion failed");
`else
`define MCES_ASSERT_IMP(lbl, ante, cons)
`define MCES_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/mces_pkg.sv
// Types and constants for the encoder speed block.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mces_pkg;
	localparam int CHANNELS  = 4;
	localparam int CH_W      = 2;
	localparam int CNT_W     = 32;
	localparam int IVL_W     = 16;
	localparam int NARROW_W  = 16;
	localparam int MS_PER_S  = 1000;
	localparam int MS_W      = 10;
	// |delta| * 1000 stays below 2^41
	localparam int PROD_W    = 41;
	localparam int STEP_W    = $clog2(PROD_W);

	typedef logic [CHANNELS-1:0]      mask_t;
	typedef logic [CH_W-1:0]          chan_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [CNT_W-1:0]  sword_t;
	typedef logic [IVL_W-1:0]         ivl_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [STEP_W-1:0]        step_t;

	localparam mask_t  MASK_RESET = mask_t'(2);
	localparam sword_t SPEED_MAX  = 32'sh7FFF_FFFF;
	localparam sword_t SPEED_MIN  = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_MEASURE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/mces_if.sv
// Valid/ready channel interfaces for the encoder speed block.
// Depends on mces_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mces_in_if;
	import mces_pkg::*;
	logic  valid;
	logic  ready;
	logic  [1:0] opcode;
	chan_t channel;
	cnt_t  counter_value;
	ivl_t  interval_ms;
	modport source (output valid, opcode, channel, counter_value, interval_ms, input ready);
	modport sink (input valid, opcode, channel, counter_value, interval_ms, output ready);
endinterface

interface mces_out_if;
	import mces_pkg::*;
	logic   valid;
	logic   ready;
	chan_t  result_channel;
	sword_t delta_count;
	sword_t speed;
	cnt_t   last_counter;
	modport source (output valid, result_channel, delta_count, speed, last_counter, input ready);
	modport sink (input valid, result_channel, delta_count, speed, last_counter, output ready);
endinterface
`default_nettype wire

FILE: rtl/multi_channel_encoder_speed.sv
// Four-channel encoder speed block (M method). A measure passes through a multiply state,
// 41 restoring divide steps and a finish state; start and read go straight to finish.
// One transaction in flight: a new request is taken only in idle, and the finish state waits
// for out_ch.ready while an unread result is held; a dropped transaction stays in idle.
// arst_n clears state, the mask to 2.
// Depends on mces_pkg, mces_if and multi_channel_encoder_speed_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_encoder_speed_macros.svh"
module multi_channel_encoder_speed (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire mces_pkg::mask_t cfg_wdata,
	mces_in_if.sink              in_ch,
	mces_out_if.source           out_ch
);
	import mces_pkg::*;

	// control state
	state_t state_q, state_d;
	logic   out_valid_q;
	mask_t  mask_q;

	// per-channel store
	cnt_t   last_count_q [CHANNELS];
	sword_t stored_delta_q [CHANNELS];
	sword_t stored_speed_q [CHANNELS];

	// captured transaction
	logic [1:0] op_q;
	chan_t      ch_q;
	cnt_t       cnt_q;
	ivl_t       ivl_q;

	// arithmetic working registers
	sword_t delta_q;
	logic   neg_q;
	prod_t  quo_q;   // dividend shifts out at the top, quotient in at the bottom
	ivl_t   rem_q;
	step_t  step_q;

	// output register
	chan_t  out_ch_q;
	sword_t out_delta_q;
	sword_t out_speed_q;
	cnt_t   out_last_q;

	logic   in_accept;
	logic   load_mul;
	logic   div_run;
	logic   fin_go;

	cnt_t   diff;
	sword_t delta_new;
	cnt_t   mag;
	prod_t  product;
	logic [IVL_W:0] trial;
	logic   q_bit;
	ivl_t   rem_next;
	sword_t sat_speed;
	logic   pos_ovf;
	logic   neg_ovf;
	sword_t res_delta;
	sword_t res_speed;
	cnt_t   res_last;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					case (in_ch.opcode)
						OP_START, OP_READ: state_d = S_FIN;
						OP_MEASURE: begin
							if (in_ch.interval_ms != '0) begin
								state_d = S_MUL;
							end
						end
						default: state_d = S_IDLE;   // unused opcode: dropped
					endcase
				end
			end
			S_MUL: state_d = S_DIV;
			S_DIV: begin
				if (step_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		in_ch.ready = (state_q == S_IDLE);
		in_accept   = in_ch.valid && (state_q == S_IDLE);
		load_mul    = (state_q == S_MUL);
		div_run     = (state_q == S_DIV);
		fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);
	end

	// ---------------- delta and magnitude product ----------------
	always_comb begin
		diff = cnt_q - last_count_q[ch_q];
		if (mask_q[ch_q]) begin
			delta_new = sword_t'(diff);
		end else begin
			delta_new = sword_t'({{(CNT_W-NARROW_W){diff[NARROW_W-1]}}, diff[NARROW_W-1:0]});
		end
		// two's complement negate; -2^31 gives 2^31 as unsigned magnitude
		mag     = delta_new[CNT_W-1] ? (~cnt_t'(delta_new) + cnt_t'(1)) : cnt_t'(delta_new);
		// constant multiply, formed at full product width
		product = prod_t'(mag) * prod_t'(MS_PER_S);
	end

	// ---------------- one restoring divide step ----------------
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		if (trial >= {1'b0, ivl_q}) begin
			q_bit    = 1'b1;
			rem_next = IVL_W'(trial - {1'b0, ivl_q});
		end else begin
			q_bit    = 1'b0;
			rem_next = trial[IVL_W-1:0];
		end
	end

	// ---------------- sign restore and int32 saturation ----------------
	always_comb begin
		pos_ovf = |quo_q[PROD_W-1:CNT_W-1];
		neg_ovf = (|quo_q[PROD_W-1:CNT_W]) || (quo_q[CNT_W-1] && (|quo_q[CNT_W-2:0]));
		if (neg_q) begin
			sat_speed = neg_ovf ? SPEED_MIN : sword_t'(~quo_q[CNT_W-1:0] + cnt_t'(1));
		end else begin
			sat_speed = pos_ovf ? SPEED_MAX : sword_t'(quo_q[CNT_W-1:0]);
		end
	end

	// ---------------- result selection ----------------
	always_comb begin
		case (op_q)
			OP_START: begin
				res_delta = '0;
				res_speed = '0;
				res_last  = cnt_q;
			end
			OP_MEASURE: begin
				res_delta = delta_q;
				res_speed = sat_speed;
				res_last  = cnt_q;
			end
			default: begin   // read
				res_delta = stored_delta_q[ch_q];
				res_speed = stored_speed_q[ch_q];
				res_last  = last_count_q[ch_q];
			end
		endcase
	end

	// ---------------- control registers and channel store ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mask_q      <= MASK_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				last_count_q[i]   <= '0;
				stored_delta_q[i] <= '0;
				stored_speed_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_go) begin
				last_count_q[ch_q]   <= res_last;
				stored_delta_q[ch_q] <= res_delta;
				stored_speed_q[ch_q] <= res_speed;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= in_ch.opcode;
			ch_q  <= in_ch.channel;
			cnt_q <= in_ch.counter_value;
			ivl_q <= in_ch.interval_ms;
		end
		if (load_mul) begin
			delta_q <= delta_new;
			neg_q   <= delta_new[CNT_W-1];
			quo_q   <= product;
			rem_q   <= '0;
			step_q  <= step_t'(PROD_W - 1);
		end else if (div_run) begin
			quo_q  <= {quo_q[PROD_W-2:0], q_bit};
			rem_q  <= rem_next;
			step_q <= step_q - step_t'(1);
		end
		if (fin_go) begin
			out_ch_q    <= ch_q;
			out_delta_q <= res_delta;
			out_speed_q <= res_speed;
			out_last_q  <= res_last;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_channel = out_ch_q;
	assign out_ch.delta_count    = out_delta_q;
	assign out_ch.speed          = out_speed_q;
	assign out_ch.last_counter   = out_last_q;

	// ---------------- assertions ----------------
	// divider never runs on a zero interval
	`MCES_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, ivl_q != '0)
	// a finished transaction always lands in the output register
	`MCES_ASSERT_NXT(a_fin_out, fin_go, out_valid_q)
	// unused opcode is dropped without leaving idle
	`MCES_ASSERT_NXT(a_drop_op, in_accept && in_ch.opcode > OP_READ, state_q == S_IDLE)
endmodule
`default_nettype wire
